@@ sv/stable_priority_queue_macros.svh @@
// Assertion macros for the stable priority queue.
// Used by the top level; expects clk and arst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/spq_pkg.sv @@
// Shared types, widths and codes for the stable priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TAG_W    = 16;
	localparam int AGE_W    = 8;
	localparam int PRI_W    = 2;
	localparam int OCC_W    = 5;
	localparam int ST_W     = 2;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ins;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// One slot of the sorted queue row: holds one entry, compares it against the
// incoming entry and shifts toward either neighbor. Depends on spq_pkg.
`default_nettype none

module spq_cell (
	input  wire logic              clk,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire logic              occupied,
	input  wire logic              prev_keep,
	input  wire spq_pkg::entry_t   prev_entry,
	input  wire spq_pkg::entry_t   next_entry,
	output logic                   keep,
	output spq_pkg::entry_t        entry
);

	spq_pkg::entry_t entry_q;

	// Stay in place when the new entry sorts behind this one.
	assign keep  = occupied && (entry_q.pri <= ctl.ins.pri);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		priority if (ctl.deq) begin
			entry_q <= next_entry;
		end else if (ctl.enq && !keep) begin
			if (prev_keep) begin
				entry_q <= ctl.ins;
			end else begin
				entry_q <= prev_entry;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/stable_priority_queue.sv @@
// Stable priority queue: a row of CAPACITY cells kept sorted by priority code.
// A result beat is shown in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while the result side is not stalled;
// every cell compares and shifts at once, so the cell update sets the rate.
// Reset clears the entry count and the output valid; stored entries are not
// cleared and only entries below the count are ever read.
`default_nettype none
`include "stable_priority_queue_macros.svh"

module stable_priority_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Input beats
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// [15:0] name_tag, [23:16] age, [25:24] priority_req, [31:26] zero
	input  wire logic [spq_pkg::S_DATA_W-1:0] s_tdata,
	// [0] command
	input  wire logic                         s_tuser,
	// Result beats
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [15:0] out_tag, [23:16] out_age, [25:24] out_priority,
	// [30:26] occupancy, [31] zero
	output logic [spq_pkg::M_DATA_W-1:0]      m_tdata,
	// [1:0] status
	output logic [spq_pkg::ST_W-1:0]          m_tuser
);

	localparam int N = spq_pkg::CAPACITY;
	localparam logic [spq_pkg::CNT_W-1:0] CNT_FULL = spq_pkg::CNT_W'(N);
	localparam logic [spq_pkg::CNT_W-1:0] CNT_TWO  = spq_pkg::CNT_W'(2);

	// Entry count and output register.
	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      out_valid_q;
	spq_pkg::status_t          out_status_q;
	spq_pkg::entry_t           out_entry_q;
	logic [spq_pkg::OCC_W-1:0] out_occ_q;

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic                      is_deq;
	logic                      enq_ok;
	logic                      deq_ok;
	spq_pkg::cell_ctl_t        ctl;
	spq_pkg::entry_t           in_entry;
	logic [spq_pkg::CNT_W-1:0] count_nxt;
	logic                      res_no_entry;

	spq_pkg::entry_t           entry_w [N];
	logic                      keep_w  [N];
	logic                      occ_w   [N];

	// Take a new beat whenever the output register is free or being drained.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);
	assign is_deq = (spq_pkg::cmd_t'(s_tuser) == spq_pkg::CMD_DEQ);
	assign enq_ok = accept && !is_deq && !full;
	assign deq_ok = accept && is_deq && !empty;

	assign in_entry.tag = s_tdata[15:0];
	assign in_entry.age = s_tdata[23:16];
	assign in_entry.pri = s_tdata[25:24];

	assign ctl.enq = enq_ok;
	assign ctl.deq = deq_ok;
	assign ctl.ins = in_entry;

	always_comb begin
		count_nxt = count_q;
		if (enq_ok) begin
			count_nxt = count_q + 1'b1;
		end else if (deq_ok) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// Cell row: head at index zero. Each cell looks at its left neighbor's
	// keep decision to find the insertion point, and pulls from the right
	// on a dequeue.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic            prev_keep;
		spq_pkg::entry_t prev_entry;
		spq_pkg::entry_t next_entry;

		assign occ_w[i] = (spq_pkg::CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_entry = in_entry;
		end else begin : g_body
			assign prev_keep  = keep_w[i-1];
			assign prev_entry = entry_w[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_entry = entry_w[i];
		end else begin : g_inner
			assign next_entry = entry_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ_w[i]),
			.prev_keep  (prev_keep),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.keep       (keep_w[i]),
			.entry      (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on every accepted beat, hold while stalled.
	// Only a dequeue that finds an entry returns a payload; zero it otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_entry_q <= deq_ok ? entry_w[0] : '0;
			out_occ_q   <= spq_pkg::OCC_W'(count_nxt);
			if (is_deq) begin
				if (empty) begin
					out_status_q <= spq_pkg::ST_EMPTY;
				end else begin
					out_status_q <= spq_pkg::ST_DEQUEUED;
				end
			end else begin
				if (full) begin
					out_status_q <= spq_pkg::ST_FULL;
				end else begin
					out_status_q <= spq_pkg::ST_ENQUEUED;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_occ_q, out_entry_q.pri, out_entry_q.age, out_entry_q.tag};

	// Checks
	assign res_no_entry = out_valid_q && (out_status_q != spq_pkg::ST_DEQUEUED);

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL, "entry count above capacity")
	`SPQ_ASSERT_NEXT(a_enq_count, enq_ok, count_q == $past(count_q) + 1'b1, "count did not grow")
	`SPQ_ASSERT_NOW(a_zero_payload, res_no_entry, out_entry_q == '0, "payload without dequeue")
	`SPQ_ASSERT_NOW(a_head_order, count_q >= CNT_TWO, entry_w[0].pri <= entry_w[1].pri, "head order")

endmodule

`default_nettype wire

@@ tb/stable_priority_queue_checker.sv @@
// Result checker for the stable priority queue: watches both streams, keeps its own
// sorted copy of the stored entries and compares every result beat with the prediction.
// Depends on spq_pkg for the entry, command and status types.
`default_nettype none

module stable_priority_queue_checker
	import spq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_DATA_W-1:0]   m_tdata,
	input  wire logic [ST_W-1:0]       m_tuser,
	output int                         mismatches,
	output int                         outstanding
);

	typedef struct {
		status_t           st;
		entry_t            removed;
		logic [OCC_W-1:0]  occ;
	} queue_result_t;

	// Shadow of the queue contents, head at index 0.
	entry_t        shadow_slots [CAPACITY];
	int            shadow_count;
	queue_result_t pending_results [$];
	int            result_index;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		shadow_count = 0;
		result_index = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("result %0d: %s expected 0x%0h, got 0x%0h", result_index, what, want, got);
		mismatches++;
	endtask

	// Apply one operation to the shadow queue and return the result it must produce.
	function automatic queue_result_t queue_operation(input cmd_t cmd, input entry_t item);
		queue_result_t r;
		int            pos;
		r.st      = ST_ENQUEUED;
		r.removed = '0;
		if (cmd == CMD_ENQ) begin
			if (shadow_count >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				// Insert after every entry of equal or better code, so ties stay in order.
				pos = 0;
				while (pos < shadow_count && shadow_slots[pos].pri <= item.pri)
					pos++;
				for (int i = shadow_count; i > pos; i--)
					shadow_slots[i] = shadow_slots[i - 1];
				shadow_slots[pos] = item;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.st = ST_EMPTY;
		end else begin
			r.st      = ST_DEQUEUED;
			r.removed = shadow_slots[0];
			for (int i = 1; i < shadow_count; i++)
				shadow_slots[i - 1] = shadow_slots[i];
			shadow_count--;
		end
		r.occ = shadow_count[OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		queue_result_t want;
		entry_t        item;
		if (arst_n) begin
			// Check the result beat first: it belongs to an earlier input beat.
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with nothing pending", 0, m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.st)
						report_mismatch("status", want.st, m_tuser);
					if (m_tdata[15:0] !== want.removed.tag)
						report_mismatch("out_tag", want.removed.tag, m_tdata[15:0]);
					if (m_tdata[23:16] !== want.removed.age)
						report_mismatch("out_age", want.removed.age, m_tdata[23:16]);
					if (m_tdata[25:24] !== want.removed.pri)
						report_mismatch("out_priority", want.removed.pri, m_tdata[25:24]);
					if (m_tdata[30:26] !== want.occ)
						report_mismatch("occupancy", want.occ, m_tdata[30:26]);
					if (m_tdata[31] !== 1'b0)
						report_mismatch("tdata pad bit", 0, m_tdata[31]);
				end
				result_index++;
			end
			if (s_tvalid && s_tready) begin
				item.tag = s_tdata[15:0];
				item.age = s_tdata[23:16];
				item.pri = s_tdata[25:24];
				pending_results.push_back(queue_operation(cmd_t'(s_tuser), item));
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/stable_priority_queue_test.sv @@
// Top of the stable priority queue testbench: clock, reset, operation stimulus,
// result back-pressure and the verdict. Depends on spq_pkg, the block and the checker.
`default_nettype none

module stable_priority_queue_test;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_ITEMS  = 100;
	localparam int PHASE_COUNT  = 7;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [ST_W-1:0]     m_tuser;

	int   mismatches;
	int   outstanding;
	int   cycle_count;
	// Set for a stretch with no idling on either side.
	logic steady;
	// Bumped to ask the result side for one long hold-off.
	int   hold_request;

	stable_priority_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	stable_priority_queue_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Guard against a hang: end the run once the cycle budget is spent.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: drop ready with a 12 percent chance, hold off for a long
	// stretch on request, and keep ready high throughout a steady stretch.
	initial begin : result_sink
		int hold_seen;
		hold_seen = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_request) begin
				hold_seen = hold_request;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 12);
		end
	end

	// Offer one operation beat and hold it until accepted, then, unless steady, sometimes drop valid.
	task automatic offer_op(input cmd_t cmd, input logic [TAG_W-1:0] tag,
			input logic [AGE_W-1:0] age, input logic [PRI_W-1:0] pri);
		s_tdata  <= {6'd0, pri, age, tag};
		s_tuser  <= cmd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (!steady && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted result beat has come back.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Random operation; priority code zero shows up now and then.
	task automatic random_op(input int enq_percent);
		cmd_t             cmd;
		logic [PRI_W-1:0] pri;
		cmd = ($urandom_range(0, 99) < enq_percent) ? CMD_ENQ : CMD_DEQ;
		pri = ($urandom_range(0, 9) == 0) ? 2'd0 : PRI_W'($urandom_range(1, 3));
		offer_op(cmd, TAG_W'($urandom), AGE_W'($urandom), pri);
	endtask

	initial begin : stimulus
		// Enqueue share per random phase: swing between filling and draining so
		// both the full and the empty cases come up again and again.
		int enq_share [PHASE_COUNT];
		enq_share = '{80, 20, 60, 90, 10, 50, 50};

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = CMD_ENQ;
		steady       = 1'b0;
		hold_request = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dequeue while empty first.
		offer_op(CMD_DEQ, 16'hFFFF, 8'hFF, 2'd3);
		// Field extremes and every priority code, zero included.
		offer_op(CMD_ENQ, 16'hFFFF, 8'hFF, 2'd3);
		offer_op(CMD_ENQ, 16'h0000, 8'h00, 2'd1);
		offer_op(CMD_ENQ, 16'h1234, 8'h5A, 2'd2);
		offer_op(CMD_ENQ, 16'hA5A5, 8'h3C, 2'd0);
		// Fill to capacity with repeated codes so ties must keep arrival order.
		for (int i = 0; i < CAPACITY - 4; i++)
			offer_op(CMD_ENQ, TAG_W'(16'h0100 + i), AGE_W'(i), PRI_W'(i % 4));
		// Enqueue into a full queue, even at the best code: dropped.
		offer_op(CMD_ENQ, 16'hBEEF, 8'h81, 2'd0);
		// Payload on a dequeue is ignored.
		for (int i = 0; i < 4; i++)
			offer_op(CMD_DEQ, TAG_W'($urandom), AGE_W'($urandom), PRI_W'($urandom));
		wait_for_results();

		// Random phases.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			steady <= (phase == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Long receiver hold-off while beats keep coming: stall the input.
				if ((phase == 1 || phase == 5) && n == 20)
					hold_request <= hold_request + 1;
				random_op(enq_share[phase]);
			end
			if (phase == 3)
				wait_for_results();
		end

		wait_for_results();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
tb/stable_priority_queue_checker.sv
tb/stable_priority_queue_test.sv
